// ===== rtl/morse_char_keyer_assert.svh =====
// Assertion macros shared by the keyer checker.
// Depends on clk and rst being visible where a macro is used.
`ifndef MORSE_CHAR_KEYER_ASSERT_SVH
`define MORSE_CHAR_KEYER_ASSERT_SVH

// Check a property on every clock edge outside of reset.
`define MCK_ASSERT_RUN(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("keyer assertion failed");

// Check a property on every clock edge, reset included.
`define MCK_ASSERT_ANY(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("keyer reset assertion failed");

`endif

// ===== rtl/mck_pkg.sv =====
// Shared types, constants, Morse symbol table and microcode ROM for the keyer.
// No dependencies; the register, sequencer, datapath and top-level files import it.
package mck_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register indexes (byte address 4*i)
  localparam logic [2:0] REG_LAMP_LEVEL  = 3'd0;
  localparam logic [2:0] REG_DOT_TIME    = 3'd1;
  localparam logic [2:0] REG_DASH_TIME   = 3'd2;
  localparam logic [2:0] REG_ELEMENT_GAP = 3'd3;
  localparam logic [2:0] REG_LETTER_GAP  = 3'd4;
  localparam logic [2:0] REG_LINE_PAUSE  = 3'd5;

  localparam logic [7:0]  RST_LAMP_LEVEL  = 8'd100;
  localparam logic [15:0] RST_DOT_TIME    = 16'd300;
  localparam logic [15:0] RST_DASH_TIME   = 16'd1000;
  localparam logic [15:0] RST_ELEMENT_GAP = 16'd200;
  localparam logic [15:0] RST_LETTER_GAP  = 16'd750;
  localparam logic [15:0] RST_LINE_PAUSE  = 16'd2000;

  localparam logic [15:0] ERR_ON_MS   = 16'd100;
  localparam logic [15:0] ERR_OFF_MS  = 16'd25;
  localparam logic [2:0]  ERR_FLASHES = 3'd5;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_APOS    = 8'h27;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_HYPHEN  = 8'h2D;

  typedef struct packed {
    logic [7:0]  lamp_level;
    logic [15:0] dot_time;
    logic [15:0] dash_time;
    logic [15:0] element_gap;
    logic [15:0] letter_gap;
    logic [15:0] line_pause;
  } cfg_t;

  typedef enum logic [1:0] {
    CLS_MORSE,
    CLS_SPACE,
    CLS_LINE,
    CLS_BAD
  } cls_t;

  typedef enum logic [3:0] {
    STEP_FETCH,
    STEP_ELEM_ON,
    STEP_ELEM_GAP,
    STEP_CHAR_END,
    STEP_ERR_ON,
    STEP_ERR_OFF,
    STEP_ERR_END,
    STEP_SPACE,
    STEP_LINE
  } step_t;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_JUMP,
    COND_DISPATCH,
    COND_MORE_ELEM,
    COND_MORE_FLASH
  } cond_t;

  typedef enum logic [2:0] {
    DUR_ELEM,
    DUR_EGAP,
    DUR_LGAP,
    DUR_LINE,
    DUR_ERR_ON,
    DUR_ERR_OFF
  } dur_sel_t;

  typedef enum logic [1:0] {
    LAMP_NONE,
    LAMP_MORSE,
    LAMP_ERROR
  } lamp_sel_t;

  typedef struct packed {
    logic      fetch;
    logic      emit;
    dur_sel_t  dur_sel;
    lamp_sel_t lamp_sel;
    logic      tone;
    logic      invalid;
    logic      last;
    logic      shift_elem;
    logic      dec_flash;
    cond_t     cond;
    step_t     target;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    cls_t cls;
    logic more_elem;
    logic more_flash;
    logic out_free;
  } stat_t;

  typedef struct packed {
    cls_t       cls;
    logic [2:0] len;
    logic [5:0] pat;   // first element in bit 5, 1 = dash
  } sym_t;

  // Morse table: {length, left-aligned pattern}
  function automatic logic [8:0] morse_entry(input logic [5:0] idx);
    logic [8:0] e;
    case (idx)
      6'd0:  e = {3'd2, 6'b010000}; // A
      6'd1:  e = {3'd4, 6'b100000}; // B
      6'd2:  e = {3'd4, 6'b101000}; // C
      6'd3:  e = {3'd3, 6'b100000}; // D
      6'd4:  e = {3'd1, 6'b000000}; // E
      6'd5:  e = {3'd4, 6'b001000}; // F
      6'd6:  e = {3'd3, 6'b110000}; // G
      6'd7:  e = {3'd4, 6'b000000}; // H
      6'd8:  e = {3'd2, 6'b000000}; // I
      6'd9:  e = {3'd4, 6'b011100}; // J
      6'd10: e = {3'd3, 6'b101000}; // K
      6'd11: e = {3'd4, 6'b010000}; // L
      6'd12: e = {3'd2, 6'b110000}; // M
      6'd13: e = {3'd2, 6'b100000}; // N
      6'd14: e = {3'd3, 6'b111000}; // O
      6'd15: e = {3'd4, 6'b011000}; // P
      6'd16: e = {3'd4, 6'b110100}; // Q
      6'd17: e = {3'd3, 6'b010000}; // R
      6'd18: e = {3'd3, 6'b000000}; // S
      6'd19: e = {3'd1, 6'b100000}; // T
      6'd20: e = {3'd3, 6'b001000}; // U
      6'd21: e = {3'd4, 6'b000100}; // V
      6'd22: e = {3'd3, 6'b011000}; // W
      6'd23: e = {3'd4, 6'b100100}; // X
      6'd24: e = {3'd4, 6'b101100}; // Y
      6'd25: e = {3'd4, 6'b110000}; // Z
      6'd26: e = {3'd5, 6'b111110}; // 0
      6'd27: e = {3'd5, 6'b011110}; // 1
      6'd28: e = {3'd5, 6'b001110}; // 2
      6'd29: e = {3'd5, 6'b000110}; // 3
      6'd30: e = {3'd5, 6'b000010}; // 4
      6'd31: e = {3'd5, 6'b000000}; // 5
      6'd32: e = {3'd5, 6'b100000}; // 6
      6'd33: e = {3'd5, 6'b110000}; // 7
      6'd34: e = {3'd5, 6'b111000}; // 8
      6'd35: e = {3'd5, 6'b111100}; // 9
      6'd36: e = {3'd6, 6'b110011}; // comma
      6'd37: e = {3'd6, 6'b010101}; // period
      6'd38: e = {3'd6, 6'b101010}; // semicolon
      6'd39: e = {3'd6, 6'b111000}; // colon
      6'd40: e = {3'd6, 6'b011110}; // apostrophe
      6'd41: e = {3'd6, 6'b010010}; // quote
      6'd42: e = {3'd6, 6'b100001}; // hyphen
      default: e = '0;
    endcase
    return e;
  endfunction

  function automatic sym_t char_decode(input logic [7:0] c);
    sym_t       s;
    logic [5:0] idx;
    s   = '0;
    idx = '0;
    s.cls = CLS_MORSE;
    if (c == CH_SPACE) begin
      s.cls = CLS_SPACE;
    end else if (c == CH_LF || c == CH_CR) begin
      s.cls = CLS_LINE;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      idx = 6'(c - CH_UPPER_A);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      idx = 6'(c - CH_LOWER_A);
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      idx = 6'(c - CH_DIGIT_0) + 6'd26;
    end else begin
      case (c)
        CH_COMMA:  idx = 6'd36;
        CH_PERIOD: idx = 6'd37;
        CH_SEMI:   idx = 6'd38;
        CH_COLON:  idx = 6'd39;
        CH_APOS:   idx = 6'd40;
        CH_QUOTE:  idx = 6'd41;
        CH_HYPHEN: idx = 6'd42;
        default:   s.cls = CLS_BAD;
      endcase
    end
    {s.len, s.pat} = morse_entry(idx);
    return s;
  endfunction

  // Dispatch ROM: entry step per byte class
  function automatic step_t dispatch_target(input cls_t cls);
    step_t t;
    case (cls)
      CLS_MORSE: t = STEP_ELEM_ON;
      CLS_SPACE: t = STEP_SPACE;
      CLS_LINE:  t = STEP_LINE;
      CLS_BAD:   t = STEP_ERR_ON;
      default:   t = STEP_ERR_ON;
    endcase
    return t;
  endfunction

  // Microcode ROM: one control word per step
  function automatic ctrl_t ucode_rom(input step_t s);
    ctrl_t c;
    c = '0;
    case (s)
      STEP_FETCH: begin
        c.fetch = 1'b1;
        c.cond  = COND_DISPATCH;
      end
      STEP_ELEM_ON: begin
        c.emit     = 1'b1;
        c.dur_sel  = DUR_ELEM;
        c.lamp_sel = LAMP_MORSE;
        c.tone     = 1'b1;
        c.cond     = COND_NEXT;
      end
      STEP_ELEM_GAP: begin
        c.emit       = 1'b1;
        c.dur_sel    = DUR_EGAP;
        c.shift_elem = 1'b1;
        c.cond       = COND_MORE_ELEM;
        c.target     = STEP_ELEM_ON;
      end
      STEP_CHAR_END: begin
        c.emit    = 1'b1;
        c.dur_sel = DUR_LGAP;
        c.last    = 1'b1;
        c.cond    = COND_JUMP;
        c.target  = STEP_FETCH;
      end
      STEP_ERR_ON: begin
        c.emit     = 1'b1;
        c.dur_sel  = DUR_ERR_ON;
        c.lamp_sel = LAMP_ERROR;
        c.invalid  = 1'b1;
        c.cond     = COND_NEXT;
      end
      STEP_ERR_OFF: begin
        c.emit      = 1'b1;
        c.dur_sel   = DUR_ERR_OFF;
        c.invalid   = 1'b1;
        c.dec_flash = 1'b1;
        c.cond      = COND_MORE_FLASH;
        c.target    = STEP_ERR_ON;
      end
      STEP_ERR_END: begin
        c.emit    = 1'b1;
        c.dur_sel = DUR_LGAP;
        c.invalid = 1'b1;
        c.last    = 1'b1;
        c.cond    = COND_JUMP;
        c.target  = STEP_FETCH;
      end
      STEP_SPACE: begin
        c.emit    = 1'b1;
        c.dur_sel = DUR_LGAP;
        c.last    = 1'b1;
        c.cond    = COND_JUMP;
        c.target  = STEP_FETCH;
      end
      STEP_LINE: begin
        c.emit    = 1'b1;
        c.dur_sel = DUR_LINE;
        c.last    = 1'b1;
        c.cond    = COND_JUMP;
        c.target  = STEP_FETCH;
      end
      default: begin
        c.cond   = COND_JUMP;
        c.target = STEP_FETCH;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/mck_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on mck_pkg for the register layout and reset values.
module mck_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mck_pkg::ADDR_W-1:0] paddr,
  input  logic [mck_pkg::DATA_W-1:0] pwdata,
  output logic [mck_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output mck_pkg::cfg_t              cfg
);
  import mck_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lamp_level  <= RST_LAMP_LEVEL;
      cfg.dot_time    <= RST_DOT_TIME;
      cfg.dash_time   <= RST_DASH_TIME;
      cfg.element_gap <= RST_ELEMENT_GAP;
      cfg.letter_gap  <= RST_LETTER_GAP;
      cfg.line_pause  <= RST_LINE_PAUSE;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LAMP_LEVEL:  cfg.lamp_level  <= pwdata[7:0];
        REG_DOT_TIME:    cfg.dot_time    <= pwdata[15:0];
        REG_DASH_TIME:   cfg.dash_time   <= pwdata[15:0];
        REG_ELEMENT_GAP: cfg.element_gap <= pwdata[15:0];
        REG_LETTER_GAP:  cfg.letter_gap  <= pwdata[15:0];
        REG_LINE_PAUSE:  cfg.line_pause  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_LAMP_LEVEL:  prdata = {24'd0, cfg.lamp_level};
      REG_DOT_TIME:    prdata = {16'd0, cfg.dot_time};
      REG_DASH_TIME:   prdata = {16'd0, cfg.dash_time};
      REG_ELEMENT_GAP: prdata = {16'd0, cfg.element_gap};
      REG_LETTER_GAP:  prdata = {16'd0, cfg.letter_gap};
      REG_LINE_PAUSE:  prdata = {16'd0, cfg.line_pause};
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== rtl/mck_seq.sv =====
// Microcode sequencer: step counter, control ROM and conditional jumps.
// Depends on mck_pkg for the ROM, dispatch table and control word types.
module mck_seq (
  input  logic           clk,
  input  logic           rst,
  input  mck_pkg::stat_t stat,
  output mck_pkg::ctrl_t ctrl
);
  import mck_pkg::*;

  step_t step;
  step_t step_next;
  step_t step_inc;

  assign ctrl     = ucode_rom(step);
  assign step_inc = step_t'(step + 4'd1);

  always_comb begin
    case (ctrl.cond)
      COND_NEXT:       step_next = step_inc;
      COND_JUMP:       step_next = ctrl.target;
      COND_DISPATCH:   step_next = stat.accept ? dispatch_target(stat.cls) : step;
      COND_MORE_ELEM:  step_next = stat.more_elem ? ctrl.target : step_inc;
      COND_MORE_FLASH: step_next = stat.more_flash ? ctrl.target : step_inc;
      default:         step_next = STEP_FETCH;
    endcase
    // hold while the output register cannot take the segment
    if (ctrl.emit && !stat.out_free) begin
      step_next = step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_FETCH;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== rtl/mck_datapath.sv =====
// Keyer datapath: byte decode, element shifter, flash counter, segment register.
// Depends on mck_pkg; driven by the control word from mck_seq.
module mck_datapath (
  input  logic           clk,
  input  logic           rst,
  input  mck_pkg::cfg_t  cfg,
  input  mck_pkg::ctrl_t ctrl,
  output mck_pkg::stat_t stat,
  input  logic           char_valid,
  output logic           char_ready,
  input  logic [7:0]     char_code,
  output logic           seg_valid,
  input  logic           seg_ready,
  output logic [7:0]     morse_level,
  output logic [7:0]     error_level,
  output logic           tone_on,
  output logic [15:0]    duration_ms,
  output logic           invalid_char,
  output logic           last_segment
);
  import mck_pkg::*;

  sym_t        sym_in;
  logic [5:0]  pat;
  logic [2:0]  elem_cnt;
  logic [2:0]  flash_cnt;
  logic        accept;
  logic        out_free;
  logic        go;
  logic [15:0] dur;

  assign sym_in     = char_decode(char_code);
  assign char_ready = ctrl.fetch;
  assign accept     = char_valid && char_ready;
  assign out_free   = !seg_valid || seg_ready;
  assign go         = ctrl.emit && out_free;

  assign stat.accept     = accept;
  assign stat.cls        = sym_in.cls;
  assign stat.more_elem  = (elem_cnt != 3'd1);
  assign stat.more_flash = (flash_cnt != 3'd1);
  assign stat.out_free   = out_free;

  always_comb begin
    case (ctrl.dur_sel)
      DUR_ELEM:    dur = pat[5] ? cfg.dash_time : cfg.dot_time;
      DUR_EGAP:    dur = cfg.element_gap;
      DUR_LGAP:    dur = cfg.letter_gap;
      DUR_LINE:    dur = cfg.line_pause;
      DUR_ERR_ON:  dur = ERR_ON_MS;
      DUR_ERR_OFF: dur = ERR_OFF_MS;
      default:     dur = '0;
    endcase
  end

  // load on transfer, then shift one element per gap
  always_ff @(posedge clk) begin
    if (accept) begin
      pat       <= sym_in.pat;
      elem_cnt  <= sym_in.len;
      flash_cnt <= ERR_FLASHES;
    end else begin
      if (go && ctrl.shift_elem) begin
        pat      <= {pat[4:0], 1'b0};
        elem_cnt <= elem_cnt - 3'd1;
      end
      if (go && ctrl.dec_flash) begin
        flash_cnt <= flash_cnt - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else if (go) begin
      seg_valid <= 1'b1;
    end else if (seg_ready) begin
      seg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      morse_level  <= (ctrl.lamp_sel == LAMP_MORSE) ? cfg.lamp_level : 8'd0;
      error_level  <= (ctrl.lamp_sel == LAMP_ERROR) ? cfg.lamp_level : 8'd0;
      tone_on      <= ctrl.tone;
      duration_ms  <= dur;
      invalid_char <= ctrl.invalid;
      last_segment <= ctrl.last;
    end
  end

endmodule

// ===== rtl/morse_char_keyer.sv =====
// Morse character keyer. A byte is taken in the fetch step; the step register then
// moves to the byte's first step, whose segment is loaded into the output register;
// further segments follow one per cycle while seg_ready is high. A byte gives 1 to 13
// segments and holds the control sequencer through its last step; output stalls hold it.
// rst (synchronous) returns the sequencer to fetch, empties the output register
// and loads the reset values of all six configuration registers.
module morse_char_keyer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mck_pkg::ADDR_W-1:0] paddr,
  input  logic [mck_pkg::DATA_W-1:0] pwdata,
  output logic [mck_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       char_valid,
  output logic                       char_ready,
  input  logic [7:0]                 char_code,
  output logic                       seg_valid,
  input  logic                       seg_ready,
  output logic [7:0]                 morse_level,
  output logic [7:0]                 error_level,
  output logic                       tone_on,
  output logic [15:0]                duration_ms,
  output logic                       invalid_char,
  output logic                       last_segment
);
  import mck_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;
  stat_t stat;

  mck_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mck_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  mck_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .ctrl         (ctrl),
    .stat         (stat),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .char_code    (char_code),
    .seg_valid    (seg_valid),
    .seg_ready    (seg_ready),
    .morse_level  (morse_level),
    .error_level  (error_level),
    .tone_on      (tone_on),
    .duration_ms  (duration_ms),
    .invalid_char (invalid_char),
    .last_segment (last_segment)
  );

endmodule

// ===== rtl/mck_checker.sv =====
// Port-level checks for the keyer, bound to the top level.
// Depends on morse_char_keyer_assert.svh for the assertion macros.
`include "morse_char_keyer_assert.svh"

module mck_checker (
  input logic        clk,
  input logic        rst,
  input logic        char_valid,
  input logic        char_ready,
  input logic        seg_valid,
  input logic        seg_ready,
  input logic [7:0]  morse_level,
  input logic [7:0]  error_level,
  input logic        tone_on,
  input logic [15:0] duration_ms,
  input logic        invalid_char,
  input logic        last_segment
);

  // after reset: output empty, ready for a byte
  `MCK_ASSERT_ANY(a_reset_idle, rst |=> (!seg_valid && char_ready))

  // a byte transfer always starts a run, so ready drops
  `MCK_ASSERT_RUN(a_busy_after_take, (char_valid && char_ready) |=> !char_ready)

  // tone segments are never the closing segment and never light the error lamp
  `MCK_ASSERT_RUN(a_tone_seg, (seg_valid && tone_on) |-> (!last_segment && error_level == 8'd0))

  // error runs keep the Morse lamp and tone dark
  `MCK_ASSERT_RUN(a_error_dark,
    (seg_valid && invalid_char) |-> (morse_level == 8'd0 && !tone_on))

  `MCK_ASSERT_RUN(a_seg_hold, (seg_valid && !seg_ready) |=> (seg_valid && $stable(duration_ms)))

endmodule

bind morse_char_keyer mck_checker u_mck_checker (.*);
